FILE: rtl/core/rpp_pkg.sv
// rpp_pkg: shared constants, request codes and types of the palette pool
// no dependencies; used by rpp_scan and refcounted_palette_pool
package rpp_pkg;

    localparam int DEF_PALETTES = 8;
    localparam int DEF_SLOTS    = 8;

    localparam int KIND_W  = 2;
    localparam int SLOT_W  = 3;
    localparam int SHEET_W = 8;
    localparam int REFS_W  = 4;
    localparam int LINK_W  = 4;
    localparam int PAL_W   = 3;
    localparam int MASK_W  = 8;

    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 8;
    localparam int ENT_W      = SHEET_W + REFS_W;

    localparam logic [KIND_W-1:0] KIND_ACQUIRE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY   = 2'd2;

    localparam logic [SHEET_W-1:0] NO_SHEET  = 8'hFF;
    localparam logic [LINK_W-1:0]  NO_ENTRY  = 4'hF;
    localparam logic [REFS_W-1:0]  REFS_MAX  = 4'hF;
    localparam logic [REFS_W-1:0]  REFS_ZERO = 4'h0;
    localparam logic [REFS_W-1:0]  REFS_ONE  = 4'h1;

    // outcome of one pass over the palette entries
    typedef struct packed {
        logic                match_found;
        logic [PAL_W-1:0]    match_idx;
        logic [REFS_W-1:0]   match_refs;
        logic                free_found;
        logic [PAL_W-1:0]    free_idx;
        logic                room;
    } scan_res_t;

endpackage

FILE: rtl/core/rpp_ram.sv
// rpp_ram: generic single-write, single-read memory with registered read data
// no dependencies
module rpp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/core/rpp_scan.sv
// rpp_scan: tracks the lowest matching and lowest free allowed entry, and whether any has room, during a pass
// depends on rpp_pkg
module rpp_scan (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        clr,
    input  logic                        en,
    input  logic [rpp_pkg::PAL_W-1:0]   idx,
    input  logic                        allowed,
    input  logic [rpp_pkg::REFS_W-1:0]  refs,
    input  logic                        sheet_hit,
    output rpp_pkg::scan_res_t          res
);
    import rpp_pkg::*;

    scan_res_t res_reg;
    scan_res_t res_next;
    logic      in_use;

    assign in_use = (refs != REFS_ZERO);
    assign res    = res_reg;

    always_comb
    begin
        res_next = res_reg;
        if (clr)
        begin
            res_next = '0;
        end
        else if (en && allowed)
        begin
            // entries arrive in rising order, so the first hit is the lowest
            if (in_use && sheet_hit && !res_reg.match_found)
            begin
                res_next.match_found = 1'b1;
                res_next.match_idx   = idx;
                res_next.match_refs  = refs;
            end
            if (!in_use && !res_reg.free_found)
            begin
                res_next.free_found = 1'b1;
                res_next.free_idx   = idx;
            end
            if (!in_use || sheet_hit)
            begin
                res_next.room = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg <= '0;
        end
        else
        begin
            res_reg <= res_next;
        end
    end

endmodule

FILE: rtl/core/refcounted_palette_pool.sv
// refcounted_palette_pool: top level, request sequencer over the entry and slot memories
// depends on rpp_pkg, rpp_ram, rpp_scan
// sequence: acquire reads the slot link, the linked entry if any, scans all entries, commits
//   and responds; query scans and responds; release reads the slot link and the linked entry
//   if any; an unused kind, or an out-of-range slot on acquire or release, goes to response
// requests: one at a time; the next is accepted once the result is loaded into the output
//   register, which waits while a held result is not yet taken by m_tready
// reset: rst_n clears control state, the mask to all ones and all link and entry valid bits
module refcounted_palette_pool #(
    parameter int PALETTES = rpp_pkg::DEF_PALETTES,
    parameter int SLOTS    = rpp_pkg::DEF_SLOTS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // request stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [rpp_pkg::IN_DATA_W-1:0]   s_tdata,   // slot[2:0], sheet_id[10:3], zero pad
    input  logic [rpp_pkg::KIND_W-1:0]      s_tuser,   // kind[1:0]
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [rpp_pkg::OUT_DATA_W-1:0]  m_tdata,   // ok[0], palette[3:1], fresh[4], zero pad
    // allowed entry mask write
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rpp_pkg::MASK_W-1:0]      cfg_data
);
    import rpp_pkg::*;

    localparam int PAW = (PALETTES > 1) ? $clog2(PALETTES) : 1;
    localparam int PCW = $clog2(PALETTES + 1);
    localparam int SAW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SLOT   = 3'd1;
    localparam logic [2:0] ST_OLD    = 3'd2;
    localparam logic [2:0] ST_SCAN   = 3'd3;
    localparam logic [2:0] ST_COMMIT = 3'd4;
    localparam logic [2:0] ST_RESP   = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [KIND_W-1:0]   kind_reg, kind_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [SHEET_W-1:0]  sheet_reg, sheet_next;
    logic [PAW-1:0]      rd_idx_reg;
    logic [PCW-1:0]      iss_cnt_reg, iss_cnt_next;
    logic                eval_vld_reg;
    logic                res_ok_reg, res_ok_next;
    logic [PAL_W-1:0]    res_pal_reg, res_pal_next;
    logic                res_fresh_reg, res_fresh_next;
    logic                m_valid_reg;
    logic [OUT_DATA_W-1:0] m_data_reg;
    logic [MASK_W-1:0]   mask_reg;
    logic [PALETTES-1:0] ent_vld_reg;
    logic [SLOTS-1:0]    slot_vld_reg;

    // memory ports
    logic               slot_we, slot_re;
    logic [SAW-1:0]     slot_waddr, slot_raddr;
    logic [LINK_W-1:0]  slot_wdata, slot_rdata;
    logic               ent_we, ent_re;
    logic [PAW-1:0]     ent_waddr, ent_raddr;
    logic [ENT_W-1:0]   ent_wdata, ent_rdata;

    logic               in_accept;
    logic [KIND_W-1:0]  in_kind;
    logic [SLOT_W-1:0]  in_slot;
    logic [SHEET_W-1:0] in_sheet;
    logic               in_slot_ok;
    logic [LINK_W-1:0]  old_link;
    logic [REFS_W-1:0]  rd_refs;
    logic [SHEET_W-1:0] rd_sheet;
    logic               scan_last;
    logic               out_load;
    scan_res_t          scan_res;

    assign in_kind   = s_tuser;
    assign in_slot   = s_tdata[SLOT_W-1:0];
    assign in_sheet  = s_tdata[SLOT_W +: SHEET_W];
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    assign in_slot_ok = ({1'b0, in_slot} < LINK_W'(SLOTS));

    // entries and links never written read as their reset values
    assign old_link = slot_vld_reg[slot_reg[SAW-1:0]] ? slot_rdata : NO_ENTRY;
    assign rd_refs  = ent_vld_reg[rd_idx_reg] ? ent_rdata[REFS_W-1:0] : REFS_ZERO;
    assign rd_sheet = ent_vld_reg[rd_idx_reg] ? ent_rdata[REFS_W +: SHEET_W] : NO_SHEET;

    assign scan_last = eval_vld_reg && (rd_idx_reg == PAW'(PALETTES - 1));
    assign out_load  = (state_reg == ST_RESP) && (!m_valid_reg || m_tready);

    // sheet of each entry and its reference count
    rpp_ram #(
        .WIDTH (ENT_W),
        .DEPTH (PALETTES)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .re    (ent_re),
        .raddr (ent_raddr),
        .rdata (ent_rdata)
    );

    // palette entry linked to each display slot
    rpp_ram #(
        .WIDTH (LINK_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .re    (slot_re),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    rpp_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .clr       (state_reg == ST_IDLE),
        .en        (eval_vld_reg),
        .idx       (PAL_W'(rd_idx_reg)),
        .allowed   (mask_reg[rd_idx_reg]),
        .refs      (rd_refs),
        .sheet_hit (rd_sheet == sheet_reg),
        .res       (scan_res)
    );

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        slot_next      = slot_reg;
        sheet_next     = sheet_reg;
        iss_cnt_next   = iss_cnt_reg;
        res_ok_next    = res_ok_reg;
        res_pal_next   = res_pal_reg;
        res_fresh_next = res_fresh_reg;

        slot_we    = 1'b0;
        slot_waddr = slot_reg[SAW-1:0];
        slot_wdata = NO_ENTRY;
        slot_re    = 1'b0;
        slot_raddr = in_slot[SAW-1:0];
        ent_we     = 1'b0;
        ent_waddr  = rd_idx_reg;
        ent_wdata  = {rd_sheet, rd_refs - REFS_ONE};
        ent_re     = 1'b0;
        ent_raddr  = iss_cnt_reg[PAW-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                iss_cnt_next = '0;
                if (in_accept)
                begin
                    kind_next      = in_kind;
                    slot_next      = in_slot;
                    sheet_next     = in_sheet;
                    res_ok_next    = 1'b0;
                    res_pal_next   = '0;
                    res_fresh_next = 1'b0;
                    if ((in_kind == KIND_ACQUIRE || in_kind == KIND_RELEASE) && in_slot_ok)
                    begin
                        // fetch the slot's current link
                        slot_re    = 1'b1;
                        state_next = ST_SLOT;
                    end
                    else if (in_kind == KIND_QUERY)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_RESP;
                    end
                end
            end
            ST_SLOT:
            begin
                if (old_link < LINK_W'(PALETTES))
                begin
                    // fetch the old entry to drop its reference
                    ent_re     = 1'b1;
                    ent_raddr  = old_link[PAW-1:0];
                    state_next = ST_OLD;
                end
                else
                begin
                    // stale or empty link: just unlink
                    slot_we    = 1'b1;
                    state_next = (kind_reg == KIND_ACQUIRE) ? ST_SCAN : ST_RESP;
                end
            end
            ST_OLD:
            begin
                slot_we = 1'b1;
                if (rd_refs != REFS_ZERO)
                begin
                    ent_we = 1'b1;
                    if (kind_reg == KIND_RELEASE)
                    begin
                        res_ok_next = 1'b1;
                    end
                end
                state_next = (kind_reg == KIND_ACQUIRE) ? ST_SCAN : ST_RESP;
            end
            ST_SCAN:
            begin
                // one entry read issued per cycle, evaluated in the cycle after
                if (iss_cnt_reg < PCW'(PALETTES))
                begin
                    ent_re       = 1'b1;
                    iss_cnt_next = iss_cnt_reg + PCW'(1);
                end
                if (scan_last)
                begin
                    if (kind_reg == KIND_QUERY)
                    begin
                        res_ok_next = scan_res.room || (mask_reg[rd_idx_reg]
                            && (rd_refs == REFS_ZERO || rd_sheet == sheet_reg));
                        state_next  = ST_RESP;
                    end
                    else
                    begin
                        state_next = ST_COMMIT;
                    end
                end
            end
            ST_COMMIT:
            begin
                if (scan_res.match_found)
                begin
                    // reuse an entry already holding this sheet, count saturates
                    ent_we         = 1'b1;
                    ent_waddr      = scan_res.match_idx[PAW-1:0];
                    ent_wdata      = {sheet_reg, (scan_res.match_refs == REFS_MAX) ?
                                      REFS_MAX : scan_res.match_refs + REFS_ONE};
                    slot_we        = 1'b1;
                    slot_wdata     = LINK_W'(scan_res.match_idx);
                    res_ok_next    = 1'b1;
                    res_pal_next   = scan_res.match_idx;
                end
                else if (scan_res.free_found)
                begin
                    // claim a free entry, it needs a load
                    ent_we         = 1'b1;
                    ent_waddr      = scan_res.free_idx[PAW-1:0];
                    ent_wdata      = {sheet_reg, REFS_ONE};
                    slot_we        = 1'b1;
                    slot_wdata     = LINK_W'(scan_res.free_idx);
                    res_ok_next    = 1'b1;
                    res_pal_next   = scan_res.free_idx;
                    res_fresh_next = 1'b1;
                end
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            iss_cnt_reg  <= '0;
            eval_vld_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            mask_reg     <= '1;
            ent_vld_reg  <= '0;
            slot_vld_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            iss_cnt_reg  <= iss_cnt_next;
            // a scan read is evaluated the cycle after it is issued
            eval_vld_reg <= ent_re && (state_reg == ST_SCAN);
            if (cfg_valid)
            begin
                mask_reg <= cfg_data;
            end
            if (ent_we)
            begin
                ent_vld_reg[ent_waddr] <= 1'b1;
            end
            if (slot_we)
            begin
                slot_vld_reg[slot_waddr] <= 1'b1;
            end
            if (out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        slot_reg      <= slot_next;
        sheet_reg     <= sheet_next;
        res_ok_reg    <= res_ok_next;
        res_pal_reg   <= res_pal_next;
        res_fresh_reg <= res_fresh_next;
        if (ent_re)
        begin
            rd_idx_reg <= ent_raddr;
        end
        if (out_load)
        begin
            m_data_reg <= {3'b000, res_fresh_reg, res_pal_reg, res_ok_reg};
        end
    end

    // entry memory is never read and written in the same cycle
    a_no_ent_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(ent_we && ent_re))
        else $error("entry memory read and write overlap");

    // a decrement only happens on an entry that holds a reference
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OLD && ent_we) |-> (rd_refs != REFS_ZERO))
        else $error("reference count underflow");

    // an accepted request keeps the sequencer busy in the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg != ST_IDLE))
        else $error("sequencer idle right after accept");

    // a fresh entry or a nonzero palette only comes with success
    a_result_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && (m_data_reg[4] || m_data_reg[3:1] != 3'd0)) |-> m_data_reg[0])
        else $error("result flags without success");

    // the commit step always follows a completed scan
    a_commit_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COMMIT) |-> ($past(state_reg) == ST_SCAN && $past(scan_last)))
        else $error("commit without a completed scan");

endmodule
